FILE: src/gcrt_pkg.sv
`default_nettype none

package gcrt_pkg;

  localparam int GRID_WIDTH  = 16;
  localparam int GRID_HEIGHT = 16;
  localparam int COORD_W     = 4;
  localparam int SC_W        = COORD_W + 2;
  localparam int OWNER_W     = 4;
  localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_AW     = $clog2(CELLS);
  localparam int ADDR_W      = 3;

  localparam logic REG_OWN_ID = 1'b0;

  typedef logic signed [SC_W-1:0] coord_t;
  typedef logic [1:0]             side_t;
  typedef logic [OWNER_W-1:0]     owner_t;
  typedef logic [CELL_AW-1:0]     cell_addr_t;

  typedef enum logic [2:0] {
    CMD_RESERVE_AHEAD  = 3'd0,
    CMD_RESERVE_HERE   = 3'd1,
    CMD_RELEASE_BEHIND = 3'd2,
    CMD_RELEASE_WALLED = 3'd3,
    CMD_SET_OWNER      = 3'd4,
    CMD_CLEAR_CELL     = 3'd5,
    CMD_READ_OWNER     = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_RESERVE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_EMIT,
    ST_CELL,
    ST_CELL_RD,
    ST_DONE
  } state_t;

  localparam side_t SIDE_NORTH = 2'd0;
  localparam side_t SIDE_EAST  = 2'd1;
  localparam side_t SIDE_SOUTH = 2'd2;
  localparam side_t SIDE_WEST  = 2'd3;

  function automatic coord_t side_dx(input side_t s);
    coord_t d;
    d = '0;
    if (s == SIDE_EAST) d = coord_t'(1);
    if (s == SIDE_WEST) d = coord_t'(-1);
    return d;
  endfunction

  function automatic coord_t side_dy(input side_t s);
    coord_t d;
    d = '0;
    if (s == SIDE_SOUTH) d = coord_t'(1);
    if (s == SIDE_NORTH) d = coord_t'(-1);
    return d;
  endfunction

  function automatic logic cell_ok(input coord_t x, input coord_t y);
    return (x >= 0) && (y >= 0) && (x < GRID_WIDTH) && (y < GRID_HEIGHT);
  endfunction

  function automatic cell_addr_t cell_addr(input coord_t x, input coord_t y);
    int a;
    a = int'(y) * GRID_WIDTH + int'(x);
    return cell_addr_t'(a);
  endfunction

endpackage

`default_nettype wire

FILE: src/gcrt_ram.sv
`default_nettype none

module gcrt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/grid_cell_reservation_table_core.sv
// Grid cell reservation table: a 16 by 16 table of 4-bit cell owners (0 = free) held in
// one single-port-write, registered-read RAM. After reset the block sweeps the RAM to zero,
// one cell a cycle, with s_tready low; APB writes are taken meanwhile. Each command is then
// handled alone: for a neighbour command the sequencer visits the four neighbours in the
// order north, east, south, west, passing over a side that does not apply; on one that does
// it reads the cell (ST_READ), then checks it and on a hit writes it (ST_EVAL), then for an
// announced hit loads the announcement (ST_EMIT), which waits for a free output slot. A
// single-cell command writes or reads the cell in ST_CELL, a read then passing ST_CELL_RD.
// Results leave through one output register, so the next command is taken while the
// completion still waits for m_tready.
`default_nettype none

module grid_cell_reservation_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // pos_x[3:0], pos_y[7:4], move_dir[11:8], open_sides[15:12], wall_sides[19:16],
  // new_owner[23:20]
  input  wire logic [23:0] s_tdata,
  // command[2:0]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // cell_x[3:0], cell_y[7:4], owner_read[11:8], fail_mask[15:12]
  output logic      [15:0] m_tdata,
  // kind[1:0]
  output logic      [1:0]  m_tuser,
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [gcrt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  gcrt_pkg::state_t     state, state_next;
  gcrt_pkg::owner_t     own_id;
  gcrt_pkg::cell_addr_t clr_addr;

  gcrt_pkg::cmd_t   cmd;
  gcrt_pkg::coord_t px, py, cx, cy;
  gcrt_pkg::side_t  mv, side;
  logic             here_ok, active;
  logic [3:0]       open_sides, wall_sides, fail;
  gcrt_pkg::owner_t new_owner, rd;

  logic                 ram_we, ram_re;
  gcrt_pkg::cell_addr_t ram_waddr, ram_raddr;
  gcrt_pkg::owner_t     ram_wdata, ram_rdata;

  logic load_ann, load_done, side_adv, hit_take, rd_take, accept, slot_free;

  logic             out_valid, out_last;
  gcrt_pkg::kind_t  out_kind;
  logic [3:0]       out_x, out_y, out_fail;
  gcrt_pkg::owner_t out_owner;

  gcrt_pkg::cmd_t   in_cmd;
  gcrt_pkg::coord_t in_px, in_py, in_cx, in_cy;
  gcrt_pkg::side_t  in_mv;
  logic             in_mv_ok, in_here_ok, in_active;

  gcrt_pkg::coord_t     nb_x, nb_y;
  gcrt_pkg::cell_addr_t nb_addr, here_addr;
  logic                 side_ok, hit;
  gcrt_pkg::owner_t     wr_val;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == gcrt_pkg::REG_OWN_ID) ? 32'(own_id) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= gcrt_pkg::owner_t'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == gcrt_pkg::REG_OWN_ID) begin
      own_id <= pwdata[gcrt_pkg::OWNER_W-1:0];
    end
  end

  // input decode
  always_comb begin
    in_cmd   = gcrt_pkg::cmd_t'(s_tuser);
    in_px    = gcrt_pkg::coord_t'(s_tdata[3:0]);
    in_py    = gcrt_pkg::coord_t'(s_tdata[7:4]);
    in_mv    = gcrt_pkg::SIDE_NORTH;
    in_mv_ok = 1'b1;
    unique case (s_tdata[11:8])
      4'b0001: in_mv = gcrt_pkg::SIDE_NORTH;
      4'b0010: in_mv = gcrt_pkg::SIDE_EAST;
      4'b0100: in_mv = gcrt_pkg::SIDE_SOUTH;
      4'b1000: in_mv = gcrt_pkg::SIDE_WEST;
      default: in_mv_ok = 1'b0;
    endcase
    in_here_ok = gcrt_pkg::cell_ok(in_px, in_py);
    in_cx      = in_px;
    in_cy      = in_py;
    in_active  = in_here_ok;
    case (in_cmd)
      gcrt_pkg::CMD_RESERVE_AHEAD: begin
        in_cx     = in_px + gcrt_pkg::side_dx(in_mv);
        in_cy     = in_py + gcrt_pkg::side_dy(in_mv);
        in_active = in_here_ok && in_mv_ok && gcrt_pkg::cell_ok(in_cx, in_cy);
      end
      gcrt_pkg::CMD_RELEASE_BEHIND: begin
        in_cx     = in_px + gcrt_pkg::side_dx(in_mv ^ 2'd2);
        in_cy     = in_py + gcrt_pkg::side_dy(in_mv ^ 2'd2);
        in_active = in_here_ok && in_mv_ok && gcrt_pkg::cell_ok(in_cx, in_cy);
      end
      default: ;
    endcase
  end

  // neighbor under visit
  always_comb begin
    nb_x      = cx + gcrt_pkg::side_dx(side);
    nb_y      = cy + gcrt_pkg::side_dy(side);
    nb_addr   = gcrt_pkg::cell_addr(nb_x, nb_y);
    here_addr = gcrt_pkg::cell_addr(px, py);
    side_ok   = 1'b0;
    hit       = 1'b0;
    wr_val    = '0;
    case (cmd)
      gcrt_pkg::CMD_RESERVE_AHEAD: begin
        side_ok = side != (mv ^ 2'd2);
        hit     = ram_rdata == '0;
        wr_val  = own_id;
      end
      gcrt_pkg::CMD_RESERVE_HERE: begin
        side_ok = open_sides[side];
        hit     = ram_rdata == '0;
        wr_val  = own_id;
      end
      gcrt_pkg::CMD_RELEASE_BEHIND: begin
        side_ok = side != mv;
        hit     = ram_rdata == own_id;
      end
      gcrt_pkg::CMD_RELEASE_WALLED: begin
        side_ok = wall_sides[side];
        hit     = ram_rdata != '0;
      end
      default: ;
    endcase
    side_ok = side_ok && active && gcrt_pkg::cell_ok(nb_x, nb_y);
  end

  assign slot_free = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcrt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = nb_addr;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = nb_addr;
    load_ann   = 1'b0;
    load_done  = 1'b0;
    side_adv   = 1'b0;
    hit_take   = 1'b0;
    rd_take    = 1'b0;
    unique case (state)
      gcrt_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        if (clr_addr == gcrt_pkg::cell_addr_t'(gcrt_pkg::CELLS - 1)) begin
          state_next = gcrt_pkg::ST_IDLE;
        end
      end
      gcrt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (in_cmd) inside
            gcrt_pkg::CMD_RESERVE_AHEAD, gcrt_pkg::CMD_RESERVE_HERE,
            gcrt_pkg::CMD_RELEASE_BEHIND, gcrt_pkg::CMD_RELEASE_WALLED:
              state_next = gcrt_pkg::ST_READ;
            default: state_next = gcrt_pkg::ST_CELL;
          endcase
        end
      end
      gcrt_pkg::ST_READ: begin
        if (side_ok) begin
          ram_re     = 1'b1;
          state_next = gcrt_pkg::ST_EVAL;
        end else begin
          side_adv   = 1'b1;
          state_next = (side == gcrt_pkg::SIDE_WEST) ? gcrt_pkg::ST_DONE : gcrt_pkg::ST_READ;
        end
      end
      gcrt_pkg::ST_EVAL: begin
        if (hit) begin
          ram_we    = 1'b1;
          ram_wdata = wr_val;
          hit_take  = 1'b1;
        end
        if (hit && cmd != gcrt_pkg::CMD_RESERVE_HERE) begin
          state_next = gcrt_pkg::ST_EMIT;
        end else begin
          side_adv   = 1'b1;
          state_next = (side == gcrt_pkg::SIDE_WEST) ? gcrt_pkg::ST_DONE : gcrt_pkg::ST_READ;
        end
      end
      gcrt_pkg::ST_EMIT: begin
        if (slot_free) begin
          load_ann   = 1'b1;
          side_adv   = 1'b1;
          state_next = (side == gcrt_pkg::SIDE_WEST) ? gcrt_pkg::ST_DONE : gcrt_pkg::ST_READ;
        end
      end
      gcrt_pkg::ST_CELL: begin
        ram_waddr  = here_addr;
        ram_raddr  = here_addr;
        state_next = gcrt_pkg::ST_DONE;
        case (cmd)
          gcrt_pkg::CMD_SET_OWNER: begin
            ram_we    = here_ok;
            ram_wdata = new_owner;
          end
          gcrt_pkg::CMD_CLEAR_CELL: begin
            ram_we = here_ok;
          end
          gcrt_pkg::CMD_READ_OWNER: begin
            ram_re     = 1'b1;
            state_next = gcrt_pkg::ST_CELL_RD;
          end
          default: ;
        endcase
      end
      gcrt_pkg::ST_CELL_RD: begin
        rd_take    = 1'b1;
        state_next = gcrt_pkg::ST_DONE;
      end
      gcrt_pkg::ST_DONE: begin
        if (slot_free) begin
          load_done  = 1'b1;
          state_next = gcrt_pkg::ST_IDLE;
        end
      end
      default: state_next = gcrt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == gcrt_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // command context
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= in_cmd;
      px         <= in_px;
      py         <= in_py;
      cx         <= in_cx;
      cy         <= in_cy;
      mv         <= in_mv;
      here_ok    <= in_here_ok;
      active     <= in_active;
      open_sides <= s_tdata[15:12];
      wall_sides <= s_tdata[19:16];
      new_owner  <= s_tdata[23:20];
      side       <= gcrt_pkg::SIDE_NORTH;
      fail       <= 4'hF;
      rd         <= '0;
    end else begin
      if (side_adv) begin
        side <= side + 2'd1;
      end
      if (hit_take && cmd == gcrt_pkg::CMD_RESERVE_AHEAD) begin
        fail[side] <= 1'b0;
      end
      if (rd_take) begin
        rd <= here_ok ? ram_rdata : '0;
      end
    end
  end

  gcrt_ram #(
    .WIDTH(gcrt_pkg::OWNER_W),
    .DEPTH(gcrt_pkg::CELLS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ann || load_done) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ann) begin
      out_kind  <= (cmd == gcrt_pkg::CMD_RESERVE_AHEAD) ? gcrt_pkg::KIND_RESERVE
                                                         : gcrt_pkg::KIND_RELEASE;
      out_x     <= nb_x[3:0];
      out_y     <= nb_y[3:0];
      out_owner <= '0;
      out_fail  <= '0;
      out_last  <= 1'b0;
    end else if (load_done) begin
      out_kind  <= gcrt_pkg::KIND_DONE;
      out_x     <= '0;
      out_y     <= '0;
      out_owner <= rd;
      out_fail  <= (cmd == gcrt_pkg::CMD_RESERVE_AHEAD) ? fail : 4'h0;
      out_last  <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_fail, out_owner, out_y, out_x};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

FILE: src/gcrt_checker.sv
`default_nettype none

module gcrt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a command is in progress");

  a_last_marks_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == gcrt_pkg::KIND_DONE)))
    else $error("tlast does not match completion kind");

  a_ann_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[15:8] == 8'h00)
    else $error("announcement carries owner or fail mask");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
    else $error("completion carries a cell position");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind grid_cell_reservation_table_core gcrt_checker u_gcrt_checker (.*);

`default_nettype wire
